FILE: rtl/assert_macros.svh
// Assertion helpers used by the rename bank core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rrb_pkg.sv
`default_nettype none

package rrb_pkg;

    // Widest tag index any configuration needs (up to 256 tag slots).
    localparam int PICK_TAG_W = 8;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_TAG = 1'b1;

    typedef enum logic {
        MODE_RENAME    = 1'b0,
        MODE_WRITEBACK = 1'b1
    } t_mode;

    typedef struct packed {
        logic                  found;
        logic [PICK_TAG_W-1:0] tag;
    } t_pick;

endpackage

`default_nettype wire

FILE: rtl/rrb_tag_pick.sv
`default_nettype none

module rrb_tag_pick #(
    parameter int ARCH_REGS = 32,
    parameter int TAG_SLOTS = 64
) (
    input  wire logic [TAG_SLOTS-1:0] i_tag_busy,
    output rrb_pkg::t_pick            o_pick
);

    // Priority encoder: the lowest free tag at or above ARCH_REGS wins.
    // Scanning downward lets each lower free tag overwrite a higher one.
    always_comb begin
        o_pick = '0;
        for (int t = TAG_SLOTS - 1; t >= ARCH_REGS; t--) begin
            if (!i_tag_busy[t]) begin
                o_pick.found = 1'b1;
                o_pick.tag   = rrb_pkg::PICK_TAG_W'(t);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/register_rename_bank_core.sv
// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+-------------------
// command   | in        | i_mode, i_arch_reg, i_write_value         | start high, busy low
// result    | out       | o_result_index, o_status, o_was_renamed   | o_done, one cycle
//
// An item passes from acceptance through S_LOOK to its result strobe, and a
// writeback that hits a live mapping also passes through S_OWNER: the mapped tag
// must come out of the map memory before the tag owner memory can be read.
// busy drops in the cycle that shows the result, so the next item may start then.
// Synchronous active-low reset clears the state machine, the tag busy flags, the
// mapping valid flags and the written flags of the architectural values.
// The receiver cannot stall; each result is presented for exactly one cycle.

`default_nettype none

`include "assert_macros.svh"

module register_rename_bank_core #(
    parameter int ARCH_REGS  = 32,
    parameter int TAG_SLOTS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [4:0]         i_arch_reg,
    input  wire logic signed [31:0] i_write_value,
    output logic                    o_done,
    output logic [5:0]              o_result_index,
    output logic                    o_status,
    output logic                    o_was_renamed
);

    localparam int RW = $clog2(ARCH_REGS);
    localparam int TW = $clog2(TAG_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OWNER
    } t_state;

    t_state r_state;

    // Captured item.
    rrb_pkg::t_mode           r_mode;
    logic [4:0]               r_reg;
    logic [RW-1:0]            r_reg_idx;
    logic                     r_reg_ok;
    logic [DATA_WIDTH-1:0]    r_val;

    // Flip-flop state with reset values.
    logic [TAG_SLOTS-1:0]     r_tag_busy;
    logic [ARCH_REGS-1:0]     r_map_valid;
    logic [ARCH_REGS-1:0]     r_arch_written;

    // Memories.
    logic [TW-1:0]            mem_map_tag   [ARCH_REGS];
    logic [DATA_WIDTH-1:0]    mem_arch_val  [ARCH_REGS];
    logic [RW-1:0]            mem_tag_owner [TAG_SLOTS];
    logic [DATA_WIDTH-1:0]    mem_tag_val   [TAG_SLOTS];

    // Registered read data.
    logic                     r_map_valid_rd;
    logic [TW-1:0]            r_map_tag_rd;
    logic                     r_arch_written_rd;
    logic [DATA_WIDTH-1:0]    r_arch_rd;
    logic [RW-1:0]            r_owner_rd;

    // Result registers.
    logic                     r_done;
    logic [5:0]               r_result_index;
    logic                     r_status;
    logic                     r_was_renamed;

    rrb_pkg::t_pick           pick;
    logic [TW-1:0]            pick_tag;
    logic                     accept;
    logic [RW-1:0]            in_idx;
    logic                     in_reg_ok;
    logic                     do_alloc;
    logic                     do_arch_wr;
    logic                     do_own_rd;
    logic                     do_free;
    logic [DATA_WIDTH-1:0]    arch_eff;

    rrb_tag_pick #(
        .ARCH_REGS (ARCH_REGS),
        .TAG_SLOTS (TAG_SLOTS)
    ) u_tag_pick (
        .i_tag_busy (r_tag_busy),
        .o_pick     (pick)
    );

    assign pick_tag  = TW'(pick.tag);
    assign accept    = start && (r_state == S_IDLE);
    assign in_idx    = RW'(i_arch_reg);
    assign in_reg_ok = 32'(i_arch_reg) < 32'(ARCH_REGS);

    assign do_alloc   = (r_state == S_LOOK) && (r_mode == rrb_pkg::MODE_RENAME)
                        && r_reg_ok && pick.found;
    assign do_arch_wr = (r_state == S_LOOK) && (r_mode == rrb_pkg::MODE_WRITEBACK)
                        && r_reg_ok && !r_map_valid_rd;
    assign do_own_rd  = (r_state == S_LOOK) && (r_mode == rrb_pkg::MODE_WRITEBACK)
                        && r_reg_ok && r_map_valid_rd;
    assign do_free    = (r_state == S_OWNER);

    // An architectural value never written still reads as its reset value.
    assign arch_eff = r_arch_written_rd ? r_arch_rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_done         <= 1'b0;
            r_tag_busy     <= '0;
            r_map_valid    <= '0;
            r_arch_written <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode         <= rrb_pkg::t_mode'(i_mode);
                        r_reg          <= i_arch_reg;
                        r_reg_idx      <= in_idx;
                        r_reg_ok       <= in_reg_ok;
                        r_val          <= DATA_WIDTH'(i_write_value);
                        r_map_valid_rd <= in_reg_ok && r_map_valid[in_idx];
                        r_arch_written_rd <= in_reg_ok && r_arch_written[in_idx];
                        r_state        <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_was_renamed <= 1'b0;
                    if (r_mode == rrb_pkg::MODE_RENAME) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (do_alloc) begin
                            r_tag_busy[pick_tag]   <= 1'b1;
                            r_map_valid[r_reg_idx] <= 1'b1;
                            r_result_index         <= 6'(pick_tag);
                            r_status               <= rrb_pkg::STATUS_OK;
                        end else begin
                            r_result_index <= '0;
                            r_status       <= rrb_pkg::STATUS_NO_TAG;
                        end
                    end else if (do_own_rd) begin
                        r_state <= S_OWNER;
                    end else begin
                        // Out-of-range register, or no mapping: report the register.
                        if (do_arch_wr) begin
                            r_arch_written[r_reg_idx] <= 1'b1;
                        end
                        r_done         <= 1'b1;
                        r_state        <= S_IDLE;
                        r_result_index <= 6'(r_reg);
                        r_status       <= rrb_pkg::STATUS_OK;
                    end
                end
                S_OWNER: begin
                    r_tag_busy[r_map_tag_rd] <= 1'b0;
                    r_map_valid[r_reg_idx]   <= 1'b0;
                    r_done                   <= 1'b1;
                    r_result_index           <= 6'(r_owner_rd);
                    r_status                 <= rrb_pkg::STATUS_OK;
                    r_was_renamed            <= 1'b1;
                    r_state                  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Map and architectural value memories: read on acceptance, written at the end.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_map_tag_rd <= mem_map_tag[in_idx];
            r_arch_rd    <= mem_arch_val[in_idx];
        end
        if (do_alloc) begin
            mem_map_tag[r_reg_idx] <= pick_tag;
        end else if (do_free) begin
            mem_map_tag[r_reg_idx] <= '0;
        end
        if (do_arch_wr) begin
            mem_arch_val[r_reg_idx] <= r_val;
        end
    end

    // Tag memories: owner read once the mapped tag is known.
    always_ff @(posedge i_clk) begin
        if (do_own_rd) begin
            r_owner_rd <= mem_tag_owner[r_map_tag_rd];
        end
        if (do_alloc) begin
            mem_tag_owner[pick_tag] <= r_reg_idx;
            mem_tag_val[pick_tag]   <= arch_eff;
        end else if (do_free) begin
            mem_tag_owner[r_map_tag_rd] <= '0;
            mem_tag_val[r_map_tag_rd]   <= r_val;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_index = r_result_index;
    assign o_status       = r_status;
    assign o_was_renamed  = r_was_renamed;

    `ASSERT_IMPLY(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)
    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `ASSERT_IMPLY(a_no_fail_and_free, i_clk, i_rst_n, o_done, !(o_status && o_was_renamed))
    `ASSERT_IMPLY(a_owner_needs_map, i_clk, i_rst_n, r_state == S_OWNER,
                  r_map_valid[r_reg_idx] && r_tag_busy[r_map_tag_rd])
    `ASSERT_IMPLY(a_pick_is_free, i_clk, i_rst_n, pick.found, !r_tag_busy[pick_tag])

endmodule

`default_nettype wire

FILE: bench/register_rename_bank_core_tb.sv
`timescale 1ns / 100ps

module register_rename_bank_core_tb;

    localparam int NUM_ARCH    = 32;
    localparam int NUM_TAGS    = 64;
    localparam int LEAK_BUDGET = 6;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [5:0] index;
        logic       status;
        logic       renamed;
    } t_rename_outcome;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    rrb_pkg::t_mode i_mode;
    logic [4:0]     i_arch_reg;
    logic [31:0]    i_write_value;
    logic           o_done;
    logic [5:0]     o_result_index;
    logic           o_status;
    logic           o_was_renamed;

    // Shadow copy of the rename bank state.
    logic [31:0] arch_val    [NUM_ARCH];
    logic        map_valid   [NUM_ARCH];
    logic [5:0]  map_tag     [NUM_ARCH];
    logic        tag_in_use  [NUM_TAGS];
    logic [31:0] tag_val     [NUM_TAGS];
    logic [4:0]  tag_owner_r [NUM_TAGS];
    int          stranded_tags;

    t_rename_outcome expected_outcomes[$];
    int              error_count;
    int              cycle_count;

    register_rename_bank_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_arch_reg     (i_arch_reg),
        .i_write_value  (i_write_value),
        .o_done         (o_done),
        .o_result_index (o_result_index),
        .o_status       (o_status),
        .o_was_renamed  (o_was_renamed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int free_tag_count();
        int n;
        n = 0;
        for (int t = NUM_ARCH; t < NUM_TAGS; t++)
            if (!tag_in_use[t]) n++;
        return n;
    endfunction

    function automatic t_rename_outcome predict_rename_result(rrb_pkg::t_mode mode,
                                                              logic [4:0] areg,
                                                              logic [31:0] value);
        t_rename_outcome res;
        int              pick;
        logic [5:0]      t;
        res.index   = '0;
        res.status  = rrb_pkg::STATUS_OK;
        res.renamed = 1'b0;
        pick        = -1;
        if (mode == rrb_pkg::MODE_RENAME) begin
            if (areg >= NUM_ARCH) begin
                res.status = rrb_pkg::STATUS_NO_TAG;
                return res;
            end
            for (int k = NUM_ARCH; k < NUM_TAGS && pick < 0; k++)
                if (!tag_in_use[k]) pick = k;
            if (pick < 0) begin
                res.status = rrb_pkg::STATUS_NO_TAG;
                return res;
            end
            // The previous tag of a remapped register is never released.
            if (map_valid[areg]) stranded_tags++;
            tag_in_use[pick]  = 1'b1;
            tag_val[pick]     = arch_val[areg];
            tag_owner_r[pick] = areg;
            map_valid[areg]   = 1'b1;
            map_tag[areg]     = pick[5:0];
            res.index         = pick[5:0];
            return res;
        end
        res.index = areg;
        if (areg >= NUM_ARCH) return res;
        if (map_valid[areg]) begin
            t              = map_tag[areg];
            res.index      = tag_owner_r[t];
            res.renamed    = 1'b1;
            tag_val[t]     = value;
            tag_in_use[t]  = 1'b0;
            tag_owner_r[t] = '0;
            map_valid[areg] = 1'b0;
            map_tag[areg]   = '0;
        end else begin
            arch_val[areg] = value;
        end
        return res;
    endfunction

    // Returns a register whose mapping state matches, or -1 if there is none.
    function automatic int pick_reg(bit want_mapped);
        int cand[$];
        for (int r = 0; r < NUM_ARCH; r++)
            if (map_valid[r] == want_mapped) cand.push_back(r);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'h8000_0000;
        if (r < 20) return 32'h7FFF_FFFF;
        if (r < 25) return 32'h0000_0000;
        if (r < 30) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic int random_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        t_rename_outcome exp_res;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                $error("result item arrived with nothing outstanding: index %0d",
                       o_result_index);
                error_count++;
            end else begin
                exp_res = expected_outcomes.pop_front();
                if (o_result_index !== exp_res.index) begin
                    $error("result_index mismatch: expected %0d, actual %0d",
                           exp_res.index, o_result_index);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, o_status);
                    error_count++;
                end
                if (o_was_renamed !== exp_res.renamed) begin
                    $error("was_renamed mismatch: expected %0d, actual %0d",
                           exp_res.renamed, o_was_renamed);
                    error_count++;
                end
            end
        end
    end

    // Leaves start high on return so that back-to-back items need no toggle.
    task automatic send_item(rrb_pkg::t_mode mode, logic [4:0] areg, logic [31:0] value);
        i_mode        <= mode;
        i_arch_reg    <= areg;
        i_write_value <= value;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_outcomes.push_back(predict_rename_result(mode, areg, value));
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_basic_ops();
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd0, 32'h7FFF_FFFF);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd31, 32'h8000_0000);
        send_item(rrb_pkg::MODE_RENAME, 5'd0, 32'hFFFF_FFFF);
        send_item(rrb_pkg::MODE_RENAME, 5'd31, 32'h0000_0000);
        idle_gap(2);
        send_item(rrb_pkg::MODE_RENAME, 5'd16, 32'h5555_5555);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd31, 32'hAAAA_AAAA);
        // The tag freed just above is the lowest free one again.
        send_item(rrb_pkg::MODE_RENAME, 5'd1, 32'h0000_0000);
        idle_gap(1);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd0, 32'h0000_0000);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd16, 32'hFFFF_FFFF);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd1, 32'h1234_5678);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd16, 32'h0000_0001);
    endtask

    task automatic test_remap();
        send_item(rrb_pkg::MODE_RENAME, 5'd5, 32'h0);
        send_item(rrb_pkg::MODE_RENAME, 5'd5, 32'h0);
        idle_gap(3);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd5, 32'hDEAD_BEEF);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd5, 32'h0BAD_F00D);
        send_item(rrb_pkg::MODE_RENAME, 5'd7, 32'hFFFF_FFFF);
        send_item(rrb_pkg::MODE_WRITEBACK, 5'd7, 32'h8000_0001);
    endtask

    // Fills every free tag through renames of random unmapped registers, tries renames
    // with the pool empty, then retires every mapping again.
    task automatic test_tag_exhaustion();
        int r;
        while (free_tag_count() > 0) begin
            r = pick_reg(1'b0);
            send_item(rrb_pkg::MODE_RENAME, r[4:0], rand_word());
            idle_gap(random_gap_len());
        end
        r = pick_reg(1'b0);
        if (r < 0) r = $urandom_range(0, NUM_ARCH - 1);
        send_item(rrb_pkg::MODE_RENAME, r[4:0], rand_word());
        r = pick_reg(1'b1);
        send_item(rrb_pkg::MODE_RENAME, r[4:0], rand_word());
        r = pick_reg(1'b1);
        while (r >= 0) begin
            send_item(rrb_pkg::MODE_WRITEBACK, r[4:0], rand_word());
            idle_gap(random_gap_len());
            r = pick_reg(1'b1);
        end
    endtask

    // Each phase of 100 items picks at random a rename share that fills, drains or
    // balances the tag pool, so that the pool runs dry now and then.
    task automatic test_random_mix(int count);
        int  i;
        int  r;
        int  rename_pct;
        bit  no_gaps;
        rename_pct = 50;
        no_gaps    = 1'b0;
        for (i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       rename_pct = 80;
                    1:       rename_pct = 25;
                    default: rename_pct = 50;
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (i == count / 2) wait_for_drain();
            if ($urandom_range(0, 99) < 4) begin
                // Noise: a writeback to any register, mapped or not.
                send_item(rrb_pkg::MODE_WRITEBACK, 5'($urandom_range(0, NUM_ARCH - 1)),
                          $urandom);
            end else if ($urandom_range(0, 99) < rename_pct) begin
                r = -1;
                if ($urandom_range(0, 99) < 3 && stranded_tags < LEAK_BUDGET)
                    r = pick_reg(1'b1);
                if (r < 0) r = pick_reg(1'b0);
                // All registers mapped means the pool is empty, so this rename fails.
                if (r < 0) r = $urandom_range(0, NUM_ARCH - 1);
                send_item(rrb_pkg::MODE_RENAME, r[4:0], rand_word());
            end else begin
                r = -1;
                if ($urandom_range(0, 99) < 75) r = pick_reg(1'b1);
                if (r < 0) r = $urandom_range(0, NUM_ARCH - 1);
                send_item(rrb_pkg::MODE_WRITEBACK, r[4:0], rand_word());
            end
            idle_gap(no_gaps ? 0 : random_gap_len());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_mode        <= rrb_pkg::MODE_RENAME;
        i_arch_reg    <= '0;
        i_write_value <= '0;
        cycle_count   = 0;
        error_count   = 0;
        stranded_tags = 0;
        for (int r = 0; r < NUM_ARCH; r++) begin
            arch_val[r]  = '0;
            map_valid[r] = 1'b0;
            map_tag[r]   = '0;
        end
        for (int t = 0; t < NUM_TAGS; t++) begin
            tag_in_use[t]  = 1'b0;
            tag_val[t]     = '0;
            tag_owner_r[t] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_remap();
        test_tag_exhaustion();
        test_random_mix(1770);

        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d expected results never arrived", expected_outcomes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rrb_pkg.sv
rtl/rrb_tag_pick.sv
rtl/register_rename_bank_core.sv
bench/register_rename_bank_core_tb.sv
